@@ src/nepg_pkg.sv @@
// Shared types, constants and arithmetic helpers of the noise effect pixel generator.
// Depends on nothing; every other file of the block but nepg_ifs imports it.
package nepg_pkg;

    // Effect selection codes.
    localparam logic [2:0] EFFECT_CLOUDS = 3'd0;
    localparam logic [2:0] EFFECT_LAVA   = 3'd1;
    localparam logic [2:0] EFFECT_PLASMA = 3'd2;
    localparam logic [2:0] EFFECT_FOREST = 3'd3;
    localparam logic [2:0] EFFECT_OCEAN  = 3'd4;
    localparam int unsigned NUM_EFFECTS  = 5;

    // Lattice hash and mixer constants.
    localparam logic [31:0] MIX_MUL1        = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL2        = 32'h846ca68b;
    localparam logic [31:0] HASH_X          = 32'd374761393;
    localparam logic [31:0] HASH_Y          = 32'd668265263;
    localparam logic [31:0] OCTAVE_SEED_XOR = 32'hA5A5A5A5;

    // Per-effect seeds.
    localparam logic [31:0] SEED_CLOUDS = 32'h00C10ED5;
    localparam logic [31:0] SEED_LAVA   = 32'h01A4A0A9;
    localparam logic [31:0] SEED_CRACK  = 32'h0BADC0DE;
    localparam logic [31:0] SEED_PLASMA = 32'h0051A5AA;
    localparam logic [31:0] SEED_FOREST = 32'h00F0EE57;
    localparam logic [31:0] SEED_OCEAN  = 32'h000CEA11;
    localparam logic [31:0] SEED_CREST  = 32'h00B10E55;

    // Lattice scale of each effect: lattice position = pixel * 256 / divisor.
    localparam int unsigned COORD_DIV [NUM_EFFECTS] = '{55, 45, 38, 70, 60};

    // Thresholds.
    localparam logic [7:0] CRACK_LEVEL = 8'd42;
    localparam logic [7:0] CREST_LEVEL = 8'd210;

    // Pipeline depth of one value noise unit.
    localparam int unsigned NOISE_LATENCY = 5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Gradient stops of the three gradient effects and the ocean crest tint.
    localparam rgb_t CLOUDS_LOW  = '{red: 8'd5,   green: 8'd8,   blue: 8'd20};
    localparam rgb_t CLOUDS_MID  = '{red: 8'd90,  green: 8'd110, blue: 8'd150};
    localparam rgb_t CLOUDS_HIGH = '{red: 8'd220, green: 8'd235, blue: 8'd255};
    localparam rgb_t LAVA_LOW    = '{red: 8'd5,   green: 8'd0,   blue: 8'd0};
    localparam rgb_t LAVA_MID    = '{red: 8'd255, green: 8'd60,  blue: 8'd0};
    localparam rgb_t LAVA_HIGH   = '{red: 8'd255, green: 8'd200, blue: 8'd20};
    localparam rgb_t PLASMA_LOW  = '{red: 8'd140, green: 8'd0,   blue: 8'd220};
    localparam rgb_t PLASMA_MID  = '{red: 8'd30,  green: 8'd160, blue: 8'd255};
    localparam rgb_t PLASMA_HIGH = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    localparam rgb_t CREST_TINT  = '{red: 8'd220, green: 8'd240, blue: 8'd255};

    // Noise lattice positions and seeds of one pixel.
    typedef struct packed {
        logic [15:0] xp;
        logic [15:0] yp;
        logic [31:0] seed_a;
        logic [31:0] seed_b;
        logic [31:0] seed_c;
    } coord_t;

    // Per-pixel data that travels beside the noise units.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] dxy;
        logic [7:0] vgrad;
    } side_t;

    // Exact floor(p / 255) for p up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // a + (b - a) * t / 255 with the quotient truncated toward zero.
    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] t);
        logic       neg;
        logic [7:0] mag;
        logic [7:0] q;
        neg = (b < a);
        mag = neg ? (a - b) : (b - a);
        q   = div255(16'(mag) * 16'(t));
        return neg ? (a - q) : (a + q);
    endfunction

    // a * b / 255, truncated.
    function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
        return div255(16'(a) * 16'(b));
    endfunction

endpackage

@@ src/nepg_ifs.sv @@
// Valid/ready channel interfaces for pixel words and color words.
// Depends on nothing.
interface pixel_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  pixel_col;
    logic [3:0]  pixel_row;
    logic [31:0] frame_phase;

    modport source(output valid, output pixel_col, output pixel_row, output frame_phase,
                   input ready);
    modport sink(input valid, input pixel_col, input pixel_row, input frame_phase,
                 output ready);
endinterface

interface pixel_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source(output valid, output red, output green, output blue, input ready);
    modport sink(input valid, input red, input green, input blue, output ready);
endinterface

@@ src/nepg_coord.sv @@
// First pipeline stage: lattice positions, seeds and geometric terms of one pixel.
// Depends on nepg_pkg.
module nepg_coord #(
    parameter int unsigned FRAME_WIDTH  = 48,
    parameter int unsigned FRAME_HEIGHT = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [5:0]      pixel_col,
    input  logic [3:0]      pixel_row,
    input  logic [31:0]     frame_phase,
    input  logic [2:0]      mode,
    output logic            out_valid,
    output nepg_pkg::coord_t coord,
    output nepg_pkg::side_t  side
);
    import nepg_pkg::*;

    localparam logic [7:0] CENTER_X = 8'(FRAME_WIDTH / 2);
    localparam logic [7:0] CENTER_Y = 8'(FRAME_HEIGHT / 2);

    logic [15:0] x_base [NUM_EFFECTS][64];
    logic [15:0] y_base [NUM_EFFECTS][16];
    logic [7:0]  vgrad_tab [16];

    logic     valid_reg, valid_next;
    coord_t   coord_reg, coord_next;
    side_t    side_reg, side_next;
    logic [7:0] dx, dy;

    // Constant tables of the lattice scale and the vertical gradient.
    for (genvar m = 0; m < NUM_EFFECTS; m++) begin : g_mode
        for (genvar i = 0; i < 64; i++) begin : g_col
            assign x_base[m][i] = 16'((i * 256) / COORD_DIV[m]);
        end
        for (genvar j = 0; j < 16; j++) begin : g_row
            assign y_base[m][j] = 16'((j * 256) / COORD_DIV[m]);
        end
    end
    for (genvar j = 0; j < 16; j++) begin : g_vgrad
        assign vgrad_tab[j] = 8'((j * 255) / (FRAME_HEIGHT - 1));
    end

    // Position, seeds and side data for the selected effect.
    always_comb
    begin
        coord_next = '0;
        dx = ({2'b00, pixel_col} > CENTER_X) ? ({2'b00, pixel_col} - CENTER_X)
                                             : (CENTER_X - {2'b00, pixel_col});
        dy = ({4'b0000, pixel_row} > CENTER_Y) ? ({4'b0000, pixel_row} - CENTER_Y)
                                               : (CENTER_Y - {4'b0000, pixel_row});
        side_next.mode  = mode;
        side_next.dxy   = 8'(dx * 8'd11 + dy * 8'd19);
        side_next.vgrad = vgrad_tab[pixel_row];
        unique case (mode)
            EFFECT_CLOUDS:
            begin
                coord_next.xp     = x_base[0][pixel_col] + frame_phase[24:9];
                coord_next.yp     = y_base[0][pixel_row] + frame_phase[25:10];
                coord_next.seed_a = SEED_CLOUDS;
            end
            EFFECT_LAVA:
            begin
                coord_next.xp     = x_base[1][pixel_col] + frame_phase[23:8];
                coord_next.yp     = y_base[1][pixel_row] + frame_phase[25:10];
                coord_next.seed_a = SEED_LAVA;
                coord_next.seed_c = SEED_CRACK;
            end
            EFFECT_PLASMA:
            begin
                coord_next.xp     = x_base[2][pixel_col] + frame_phase[24:9];
                coord_next.yp     = y_base[2][pixel_row] + frame_phase[26:11];
                coord_next.seed_a = SEED_PLASMA;
            end
            EFFECT_FOREST:
            begin
                coord_next.xp     = x_base[3][pixel_col] + frame_phase[25:10];
                coord_next.yp     = y_base[3][pixel_row] + frame_phase[27:12];
                coord_next.seed_a = SEED_FOREST;
            end
            EFFECT_OCEAN:
            begin
                coord_next.xp     = x_base[4][pixel_col] + frame_phase[24:9];
                coord_next.yp     = y_base[4][pixel_row] + frame_phase[26:11];
                coord_next.seed_a = SEED_OCEAN;
                coord_next.seed_c = SEED_CREST;
            end
            default:
            begin
                coord_next.xp = '0;
            end
        endcase
        coord_next.seed_b = coord_next.seed_a ^ OCTAVE_SEED_XOR;
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord_reg <= coord_next;
            side_reg  <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign coord     = coord_reg;
    assign side      = side_reg;

endmodule

@@ src/nepg_noise.sv @@
// Pipelined 2-D value noise: corner hash, two-round mixer, bilinear blend.
// Depends on nepg_pkg.
module nepg_noise (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] xp,
    input  logic [15:0] yp,
    input  logic [31:0] seed,
    output logic [7:0]  noise
);
    import nepg_pkg::*;

    // Corner order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
    logic [31:0] corner_reg [4];
    logic [31:0] corner_next [4];
    logic [31:0] mix1_reg [4];
    logic [31:0] mix1_next [4];
    logic [31:0] mix2_reg [4];
    logic [31:0] mix2_next [4];
    logic [7:0]  fx_reg [3];
    logic [7:0]  fx_next [3];
    logic [7:0]  fy_reg [4];
    logic [7:0]  fy_next [4];
    logic [7:0]  top_reg, top_next;
    logic [7:0]  bot_reg, bot_next;
    logic [7:0]  noise_reg, noise_next;
    logic [31:0] hx0, hx1, hy0, hy1;
    logic [7:0]  c8 [4];

    // Lattice corner hash.
    always_comb
    begin
        hx0 = 32'(xp[15:8]) * HASH_X;
        hx1 = 32'({1'b0, xp[15:8]} + 9'd1) * HASH_X;
        hy0 = 32'(yp[15:8]) * HASH_Y;
        hy1 = 32'({1'b0, yp[15:8]} + 9'd1) * HASH_Y;
        corner_next[0] = seed ^ hx0 ^ hy0;
        corner_next[1] = seed ^ hx1 ^ hy0;
        corner_next[2] = seed ^ hx0 ^ hy1;
        corner_next[3] = seed ^ hx1 ^ hy1;
    end

    // Mixer rounds, one multiplier per corner and stage.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            mix1_next[k] = (corner_reg[k] ^ (corner_reg[k] >> 16)) * MIX_MUL1;
            mix2_next[k] = (mix1_reg[k] ^ (mix1_reg[k] >> 15)) * MIX_MUL2;
            c8[k]        = mix2_reg[k][7:0] ^ mix2_reg[k][23:16];
        end
    end

    // Fraction bits travel alongside the corners.
    always_comb
    begin
        fx_next[0] = xp[7:0];
        fx_next[1] = fx_reg[0];
        fx_next[2] = fx_reg[1];
        fy_next[0] = yp[7:0];
        fy_next[1] = fy_reg[0];
        fy_next[2] = fy_reg[1];
        fy_next[3] = fy_reg[2];
    end

    // Horizontal then vertical interpolation.
    always_comb
    begin
        top_next   = blend(c8[0], c8[1], fx_reg[2]);
        bot_next   = blend(c8[2], c8[3], fx_reg[2]);
        noise_next = blend(top_reg, bot_reg, fy_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corner_reg <= corner_next;
            mix1_reg   <= mix1_next;
            mix2_reg   <= mix2_next;
            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            top_reg    <= top_next;
            bot_reg    <= bot_next;
            noise_reg  <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule

@@ src/nepg_shade.sv @@
// Octave sum and effect color mapping, four register stages ending in the output word.
// Depends on nepg_pkg.
module nepg_shade (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [7:0]      noise_a,
    input  logic [7:0]      noise_b,
    input  logic [7:0]      noise_c,
    input  nepg_pkg::side_t side,
    output logic            out_valid,
    output nepg_pkg::rgb_t  color
);
    import nepg_pkg::*;

    // Octave stage.
    logic       v7_reg, v7_next;
    logic [7:0] n7_reg, n7_next;
    logic [7:0] c7_reg, c7_next;
    side_t      side7_reg;

    // Effect term stage.
    logic       v8_reg, v8_next;
    logic [2:0] mode8_reg;
    logic [7:0] t1_reg, t1_next;
    logic [7:0] t2_reg, t2_next;
    logic       black8_reg, black8_next;
    rgb_t       a_reg, a_next;
    logic [7:0] aux_reg, aux_next;

    // First gradient / shading stage.
    logic       v9_reg, v9_next;
    logic [2:0] mode9_reg;
    logic [7:0] t2b_reg;
    logic       black9_reg;
    rgb_t       p_reg, p_next;

    // Output stage.
    logic       v10_reg, v10_next;
    rgb_t       out_reg, out_next;

    logic [7:0] sq, pv, psq, wave, w;
    rgb_t       lo, mid, hi;

    // Two-octave weighted sum.
    always_comb
    begin
        n7_next = div255(16'(noise_a) * 16'd166 + 16'(noise_b) * 16'd89);
        c7_next = noise_c;
        v7_next = in_valid;
    end

    // Per-effect terms from the summed noise.
    always_comb
    begin
        t1_next     = '0;
        t2_next     = '0;
        black8_next = 1'b0;
        a_next      = '0;
        aux_next    = '0;
        sq   = scale8(n7_reg, n7_reg);
        pv   = n7_reg ^ side7_reg.dxy;
        psq  = scale8(pv, pv);
        wave = (n7_reg >> 1) + (c7_reg >> 1);
        unique case (side7_reg.mode)
            EFFECT_CLOUDS:
            begin
                t1_next = sq;
                t2_next = sq >> 1;
            end
            EFFECT_LAVA:
            begin
                t1_next     = n7_reg;
                t2_next     = sq;
                black8_next = (c7_reg < CRACK_LEVEL);
            end
            EFFECT_PLASMA:
            begin
                t1_next = psq;
                t2_next = psq >> 1;
            end
            EFFECT_FOREST:
            begin
                a_next.green = 8'd40 + div255(16'(n7_reg) * 16'd180);
                a_next.red   = (n7_reg > 8'd200) ? 8'((n7_reg - 8'd200) * 8'd3) : 8'd0;
                a_next.blue  = (n7_reg < 8'd80) ? (8'd80 - n7_reg) : 8'd0;
                aux_next     = 8'd255 - (side7_reg.vgrad >> 1);
            end
            EFFECT_OCEAN:
            begin
                a_next.green = 8'd20 + div255(16'(wave) * 16'd100);
                a_next.blue  = 8'd60 + div255(16'(wave) * 16'd190);
                aux_next     = wave;
            end
            default:
            begin
                aux_next = '0;
            end
        endcase
        v8_next = v7_reg;
    end

    // Gradient stops of the current effect.
    always_comb
    begin
        unique case (mode8_reg)
            EFFECT_CLOUDS:
            begin
                lo = CLOUDS_LOW;
                mid = CLOUDS_MID;
            end
            EFFECT_LAVA:
            begin
                lo = LAVA_LOW;
                mid = LAVA_MID;
            end
            default:
            begin
                lo = PLASMA_LOW;
                mid = PLASMA_MID;
            end
        endcase
        unique case (mode9_reg)
            EFFECT_CLOUDS: hi = CLOUDS_HIGH;
            EFFECT_LAVA:   hi = LAVA_HIGH;
            default:       hi = PLASMA_HIGH;
        endcase
    end

    // First gradient blend, forest shading, ocean crest highlight.
    always_comb
    begin
        p_next = '0;
        w = 8'((aux_reg - CREST_LEVEL) * 8'd3);
        unique case (mode8_reg)
            EFFECT_CLOUDS, EFFECT_LAVA, EFFECT_PLASMA:
            begin
                p_next.red   = blend(lo.red, mid.red, t1_reg);
                p_next.green = blend(lo.green, mid.green, t1_reg);
                p_next.blue  = blend(lo.blue, mid.blue, t1_reg);
            end
            EFFECT_FOREST:
            begin
                p_next.red   = scale8(a_reg.red, aux_reg);
                p_next.green = scale8(a_reg.green, aux_reg);
                p_next.blue  = scale8(a_reg.blue, aux_reg);
            end
            EFFECT_OCEAN:
            begin
                if (aux_reg > CREST_LEVEL)
                begin
                    p_next.red   = blend(a_reg.red, CREST_TINT.red, w);
                    p_next.green = blend(a_reg.green, CREST_TINT.green, w);
                    p_next.blue  = blend(a_reg.blue, CREST_TINT.blue, w);
                end
                else
                begin
                    p_next = a_reg;
                end
            end
            default:
            begin
                p_next = '0;
            end
        endcase
        v9_next = v8_reg;
    end

    // Second gradient blend and final color select.
    always_comb
    begin
        out_next = '0;
        unique case (mode9_reg)
            EFFECT_CLOUDS, EFFECT_PLASMA:
            begin
                out_next.red   = blend(p_reg.red, hi.red, t2b_reg);
                out_next.green = blend(p_reg.green, hi.green, t2b_reg);
                out_next.blue  = blend(p_reg.blue, hi.blue, t2b_reg);
            end
            EFFECT_LAVA:
            begin
                if (!black9_reg)
                begin
                    out_next.red   = blend(p_reg.red, hi.red, t2b_reg);
                    out_next.green = blend(p_reg.green, hi.green, t2b_reg);
                    out_next.blue  = blend(p_reg.blue, hi.blue, t2b_reg);
                end
            end
            EFFECT_FOREST, EFFECT_OCEAN:
            begin
                out_next = p_reg;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
        v10_next = v9_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg  <= v7_next;
            v8_reg  <= v8_next;
            v9_reg  <= v9_next;
            v10_reg <= v10_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n7_reg     <= n7_next;
            c7_reg     <= c7_next;
            side7_reg  <= side;
            mode8_reg  <= side7_reg.mode;
            t1_reg     <= t1_next;
            t2_reg     <= t2_next;
            black8_reg <= black8_next;
            a_reg      <= a_next;
            aux_reg    <= aux_next;
            mode9_reg  <= mode8_reg;
            t2b_reg    <= t2_reg;
            black9_reg <= black8_reg;
            p_reg      <= p_next;
            out_reg    <= out_next;
        end
    end

    assign out_valid = v10_reg;
    assign color     = out_reg;

endmodule

@@ src/noise_effect_pixel_generator_unit.sv @@
// Top level of the noise effect pixel generator: effect register, pipeline glue, stall control.
// Depends on nepg_pkg, nepg_ifs, nepg_coord, nepg_noise and nepg_shade.
//
//  channel   | direction | word                                  | handshake
//  ----------+-----------+---------------------------------------+-------------------
//  pixel     | in        | pixel_col, pixel_row, frame_phase     | valid / ready
//  color     | out       | red, green, blue                      | valid / ready
//  cfg       | in        | cfg_wr_data (effect_mode)             | cfg_wr_en, no wait
//
// One pixel word is accepted per cycle unless the color side stalls. Each noise unit's depth
// is set by the lattice hash, the two mixer multiplier stages and the blend chain.
// Reset clears the effect register to clouds and all stage valid bits.
// A stall on the color side freezes every stage at once and drops pixel.ready in the same
// cycle; nothing is lost or repeated.
module noise_effect_pixel_generator_unit #(
    parameter int unsigned FRAME_WIDTH  = 48,
    parameter int unsigned FRAME_HEIGHT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    pixel_in_if.sink    pixel,
    pixel_out_if.source color,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data
);
    import nepg_pkg::*;

    logic       en;
    logic [2:0] effect_mode_reg, effect_mode_next;
    logic       coord_valid;
    coord_t     coord;
    side_t      coord_side;
    logic [7:0] noise_a, noise_b, noise_c;
    logic [15:0] xp2, yp2;
    side_t      side_pipe_reg [NOISE_LATENCY];
    side_t      side_pipe_next [NOISE_LATENCY];
    logic [NOISE_LATENCY-1:0] valid_pipe_reg, valid_pipe_next;
    logic       shade_valid;
    rgb_t       shade_color;

    // Whole pipeline advances unless the output word is held.
    assign en          = !(color.valid && !color.ready);
    assign pixel.ready = en;

    // Effect register.
    always_comb
    begin
        effect_mode_next = cfg_wr_en ? cfg_wr_data : effect_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg <= EFFECT_CLOUDS;
        end
        else
        begin
            effect_mode_reg <= effect_mode_next;
        end
    end

    nepg_coord #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_coord (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (pixel.valid),
        .pixel_col  (pixel.pixel_col),
        .pixel_row  (pixel.pixel_row),
        .frame_phase(pixel.frame_phase),
        .mode       (effect_mode_reg),
        .out_valid  (coord_valid),
        .coord      (coord),
        .side       (coord_side)
    );

    // Second octave and the extra noise layer use the doubled lattice position.
    assign xp2 = {coord.xp[14:0], 1'b0};
    assign yp2 = {coord.yp[14:0], 1'b0};

    nepg_noise u_noise_a (
        .clk  (clk),
        .en   (en),
        .xp   (coord.xp),
        .yp   (coord.yp),
        .seed (coord.seed_a),
        .noise(noise_a)
    );

    nepg_noise u_noise_b (
        .clk  (clk),
        .en   (en),
        .xp   (xp2),
        .yp   (yp2),
        .seed (coord.seed_b),
        .noise(noise_b)
    );

    nepg_noise u_noise_c (
        .clk  (clk),
        .en   (en),
        .xp   (xp2),
        .yp   (yp2),
        .seed (coord.seed_c),
        .noise(noise_c)
    );

    // Side data and valid bits ride beside the noise units.
    always_comb
    begin
        side_pipe_next[0]  = coord_side;
        valid_pipe_next[0] = coord_valid;
        for (int k = 1; k < NOISE_LATENCY; k++)
        begin
            side_pipe_next[k]  = side_pipe_reg[k-1];
            valid_pipe_next[k] = valid_pipe_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else if (en)
        begin
            valid_pipe_reg <= valid_pipe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg <= side_pipe_next;
        end
    end

    nepg_shade u_shade (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (valid_pipe_reg[NOISE_LATENCY-1]),
        .noise_a  (noise_a),
        .noise_b  (noise_b),
        .noise_c  (noise_c),
        .side     (side_pipe_reg[NOISE_LATENCY-1]),
        .out_valid(shade_valid),
        .color    (shade_color)
    );

    assign color.valid = shade_valid;
    assign color.red   = shade_color.red;
    assign color.green = shade_color.green;
    assign color.blue  = shade_color.blue;

    // A held output word must hold back the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (color.valid && !color.ready) |-> !pixel.ready)
        else $error("input accepted while output stalled");

    // An accepted pixel occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> coord_valid)
        else $error("accepted pixel missing from first stage");

    // During a stall the side valid line holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |=> $stable(valid_pipe_reg))
        else $error("side pipeline moved during stall");

endmodule
